// File: sv/tgbp_pkg.sv
package tgbp_pkg;

  localparam int unsigned GshareIndexBits  = 11;
  localparam int unsigned BimodalIndexBits = 12;
  localparam int unsigned ChooserIndexBits = 11;
  localparam int unsigned PcWidth          = 32;
  // word address starts above the byte offset
  localparam int unsigned PcWordLsb        = 2;

  typedef logic [1:0] ctr_t;

  typedef enum logic {
    KindPredict = 1'b0,
    KindTrain   = 1'b1
  } kind_e;

  localparam ctr_t CompCtrReset    = 2'd0;  // strongly not taken
  localparam ctr_t ChooserCtrReset = 2'd1;  // weakly bimodal
  localparam ctr_t CtrMax          = 2'd3;
  localparam ctr_t CtrMin          = 2'd0;

  // 2-bit saturating counter step
  function automatic ctr_t ctr_move(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CtrMax) ? CtrMax : c + 2'd1;
    end else begin
      r = (c == CtrMin) ? CtrMin : c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: sv/tgbp_if.sv
interface tgbp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [tgbp_pkg::PcWidth-1:0]     pc;
  logic                             outcome;

  modport source (output valid, output kind, output pc, output outcome, input ready);
  modport sink   (input valid, input kind, input pc, input outcome, output ready);
endinterface

interface tgbp_out_if;
  logic valid;
  logic ready;
  logic taken;

  modport source (output valid, output taken, input ready);
  modport sink   (input valid, input taken, output ready);
endinterface

// File: sv/tournament_gshare_bimodal_predictor.sv
// Channel  Dir  Payload                       Accepted when
// in_i     in   kind, pc[31:0], outcome        in_i.valid && in_i.ready
// out_o    out  taken                          out_o.valid && out_o.ready
//
// One item per cycle, unless clearing runs or a predict item waits in the
// second stage while the output register is full and out_o.ready is low.
// Tables are read at accept into a read register; the next cycle computes the
// prediction or the counter updates and writes back. After reset a clearing
// pass writes one entry of every table per cycle over 2^max(index bits)
// indices (4096 with defaults); in_i.ready stays low then.
module tournament_gshare_bimodal_predictor #(
  parameter int unsigned GSHARE_INDEX_BITS  = tgbp_pkg::GshareIndexBits,
  parameter int unsigned BIMODAL_INDEX_BITS = tgbp_pkg::BimodalIndexBits,
  parameter int unsigned CHOOSER_INDEX_BITS = tgbp_pkg::ChooserIndexBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgbp_in_if.sink     in_i,
  tgbp_out_if.source  out_o
);

  localparam int unsigned GsDepth = 1 << GSHARE_INDEX_BITS;
  localparam int unsigned BmDepth = 1 << BIMODAL_INDEX_BITS;
  localparam int unsigned ChDepth = 1 << CHOOSER_INDEX_BITS;
  localparam int unsigned GbMax   = (GSHARE_INDEX_BITS > BIMODAL_INDEX_BITS) ?
                                    GSHARE_INDEX_BITS : BIMODAL_INDEX_BITS;
  localparam int unsigned ClrBits = (GbMax > CHOOSER_INDEX_BITS) ? GbMax : CHOOSER_INDEX_BITS;

  typedef logic [GSHARE_INDEX_BITS-1:0]  gs_idx_t;
  typedef logic [BIMODAL_INDEX_BITS-1:0] bm_idx_t;
  typedef logic [CHOOSER_INDEX_BITS-1:0] ch_idx_t;

  tgbp_pkg::ctr_t gs_mem [GsDepth];
  tgbp_pkg::ctr_t bm_mem [BmDepth];
  tgbp_pkg::ctr_t ch_mem [ChDepth];

  // control
  logic                   clr_busy_q;
  logic [ClrBits-1:0]     clr_idx_q;
  gs_idx_t                hist_q, hist_d;
  logic                   s1_valid_q;
  logic                   out_valid_q;

  // stage 1 payload
  tgbp_pkg::kind_e        s1_kind_q;
  logic                   s1_outcome_q;
  gs_idx_t                s1_gi_q;
  bm_idx_t                s1_bi_q;
  ch_idx_t                s1_ci_q;
  tgbp_pkg::ctr_t         gs_rd_q, bm_rd_q, ch_rd_q;
  logic                   out_taken_q;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   s1_train;
  logic                   out_load;
  gs_idx_t                gi;
  bm_idx_t                bi;
  ch_idx_t                ci;
  logic                   gpred, bpred;

  logic                   gs_we, bm_we, ch_we;
  gs_idx_t                gs_waddr;
  bm_idx_t                bm_waddr;
  ch_idx_t                ch_waddr;
  tgbp_pkg::ctr_t         gs_wdata, bm_wdata, ch_wdata;

  assign s1_train = s1_valid_q && (s1_kind_q == tgbp_pkg::KindTrain);
  // train items never need the output register
  assign s1_adv   = !s1_valid_q || s1_train || !out_valid_q || out_o.ready;
  assign in_i.ready = s1_adv && !clr_busy_q;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = s1_valid_q && (s1_kind_q == tgbp_pkg::KindPredict) && s1_adv;

  assign gi = in_i.pc[tgbp_pkg::PcWordLsb +: GSHARE_INDEX_BITS] ^ hist_q;
  assign bi = in_i.pc[tgbp_pkg::PcWordLsb +: BIMODAL_INDEX_BITS];
  assign ci = CHOOSER_INDEX_BITS'(hist_q);

  assign hist_d = {hist_q[GSHARE_INDEX_BITS-2:0], in_i.outcome};

  assign gpred = gs_rd_q[1];
  assign bpred = bm_rd_q[1];

  always_comb begin
    if (clr_busy_q) begin
      gs_we    = 1'b1;
      bm_we    = 1'b1;
      ch_we    = 1'b1;
      gs_waddr = clr_idx_q[GSHARE_INDEX_BITS-1:0];
      bm_waddr = clr_idx_q[BIMODAL_INDEX_BITS-1:0];
      ch_waddr = clr_idx_q[CHOOSER_INDEX_BITS-1:0];
      gs_wdata = tgbp_pkg::CompCtrReset;
      bm_wdata = tgbp_pkg::CompCtrReset;
      ch_wdata = tgbp_pkg::ChooserCtrReset;
    end else begin
      gs_we    = s1_train;
      bm_we    = s1_train;
      // chooser moves only when the components disagreed
      ch_we    = s1_train && (gpred != bpred);
      gs_waddr = s1_gi_q;
      bm_waddr = s1_bi_q;
      ch_waddr = s1_ci_q;
      gs_wdata = tgbp_pkg::ctr_move(gs_rd_q, s1_outcome_q);
      bm_wdata = tgbp_pkg::ctr_move(bm_rd_q, s1_outcome_q);
      ch_wdata = tgbp_pkg::ctr_move(ch_rd_q, gpred == s1_outcome_q);
    end
  end

  // tables; a write in the same cycle as a read of that entry is forwarded
  always_ff @(posedge clk_i) begin
    if (gs_we) begin
      gs_mem[gs_waddr] <= gs_wdata;
    end
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    if (in_acc) begin
      gs_rd_q      <= (gs_we && gs_waddr == gi) ? gs_wdata : gs_mem[gi];
      bm_rd_q      <= (bm_we && bm_waddr == bi) ? bm_wdata : bm_mem[bi];
      ch_rd_q      <= (ch_we && ch_waddr == ci) ? ch_wdata : ch_mem[ci];
      s1_kind_q    <= tgbp_pkg::kind_e'(in_i.kind);
      s1_outcome_q <= in_i.outcome;
      s1_gi_q      <= gi;
      s1_bi_q      <= bi;
      s1_ci_q      <= ci;
    end
    if (out_load) begin
      out_taken_q <= ch_rd_q[1] ? gpred : bpred;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      hist_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + ClrBits'(1);
        if (clr_idx_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc && in_i.kind == tgbp_pkg::KindTrain) begin
        hist_q <= hist_d;
      end
      if (s1_adv) begin
        s1_valid_q <= in_acc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.taken = out_taken_q;

endmodule

// File: sim/tournament_gshare_bimodal_predictor_tb.sv
`timescale 1ns / 100ps

module tournament_gshare_bimodal_predictor_tb;

  localparam int unsigned GsDepth    = 1 << tgbp_pkg::GshareIndexBits;
  localparam int unsigned BmDepth    = 1 << tgbp_pkg::BimodalIndexBits;
  localparam int unsigned ChDepth    = 1 << tgbp_pkg::ChooserIndexBits;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandItems  = 500;
  localparam int unsigned CalmTail   = 60;
  localparam int unsigned HotCount   = 12;

  typedef struct {
    tgbp_pkg::kind_e              kind;
    logic [tgbp_pkg::PcWidth-1:0] pc;
    logic                         outcome;
  } branch_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tgbp_in_if  in_ch ();
  tgbp_out_if out_ch ();

  tournament_gshare_bimodal_predictor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial forever #6 clk_i = ~clk_i;

  // shadow predictor state
  logic [tgbp_pkg::GshareIndexBits-1:0] shadow_hist;
  tgbp_pkg::ctr_t gs_tab [GsDepth];
  tgbp_pkg::ctr_t bm_tab [BmDepth];
  tgbp_pkg::ctr_t ch_tab [ChDepth];

  branch_op_t op_q [$];
  logic       want_taken [$];
  int unsigned errors    = 0;
  int unsigned cycle_cnt = 0;
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;
  logic        calm      = 1'b0;

  // hot branch table for the random part
  logic [tgbp_pkg::PcWidth-1:0] br_pc     [HotCount];
  int unsigned                  br_mode   [HotCount];
  int unsigned                  br_period [HotCount];
  int unsigned                  br_phase  [HotCount];

  function automatic tgbp_pkg::ctr_t bump_ctr(tgbp_pkg::ctr_t c, logic up);
    if (up) return (c == 2'd3) ? 2'd3 : c + 2'd1;
    return (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

  // one accepted item through the shadow tables
  task automatic tourney_step(tgbp_pkg::kind_e k, logic [tgbp_pkg::PcWidth-1:0] pc,
                              logic outc);
    logic [tgbp_pkg::PcWidth-1:0]          word;
    logic [tgbp_pkg::GshareIndexBits-1:0]  gi;
    logic [tgbp_pkg::BimodalIndexBits-1:0] bi;
    logic [tgbp_pkg::ChooserIndexBits-1:0] ci;
    tgbp_pkg::ctr_t gc, bc, cc;
    logic gpred, bpred;
    word  = pc >> tgbp_pkg::PcWordLsb;
    gi    = word[tgbp_pkg::GshareIndexBits-1:0] ^ shadow_hist;
    bi    = word[tgbp_pkg::BimodalIndexBits-1:0];
    ci    = shadow_hist;
    gc    = gs_tab[gi];
    bc    = bm_tab[bi];
    cc    = ch_tab[ci];
    gpred = gc > 2'd1;
    bpred = bc > 2'd1;
    if (k == tgbp_pkg::KindPredict) begin
      want_taken.push_back((cc > 2'd1) ? gpred : bpred);
    end else begin
      shadow_hist = {shadow_hist[tgbp_pkg::GshareIndexBits-2:0], outc};
      gs_tab[gi]  = bump_ctr(gc, outc);
      bm_tab[bi]  = bump_ctr(bc, outc);
      if (gpred != bpred) ch_tab[ci] = bump_ctr(cc, gpred == outc);
    end
  endtask

  task automatic queue_op(tgbp_pkg::kind_e k, logic [tgbp_pkg::PcWidth-1:0] pc,
                          logic outc);
    branch_op_t op;
    op.kind    = k;
    op.pc      = pc;
    op.outcome = outc;
    op_q.push_back(op);
  endtask

  function automatic logic branch_dir(int unsigned b);
    logic dir;
    case (br_mode[b])
      0: dir = 1'b1;
      1: dir = 1'b0;
      2: dir = (br_phase[b] % br_period[b]) != br_period[b] - 1;
      3: dir = br_phase[b][0];
      default: dir = $urandom_range(0, 9) < 8;
    endcase
    br_phase[b]++;
    return dir;
  endfunction

  initial begin
    for (int i = 0; i < GsDepth; i++) gs_tab[i] = tgbp_pkg::CompCtrReset;
    for (int i = 0; i < BmDepth; i++) bm_tab[i] = tgbp_pkg::CompCtrReset;
    for (int i = 0; i < ChDepth; i++) ch_tab[i] = tgbp_pkg::ChooserCtrReset;
    shadow_hist   = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = tgbp_pkg::KindPredict;
    in_ch.pc      = '0;
    in_ch.outcome = 1'b0;
    out_ch.ready  = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // driver
  always @(posedge clk_i) begin
    branch_op_t op;
    logic v;
    v = in_ch.valid;
    if (!rst_ni) begin
      v = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tourney_step(tgbp_pkg::kind_e'(in_ch.kind), in_ch.pc, in_ch.outcome);
        v = 1'b0;
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (op_q.size() > 0) begin
          op = op_q.pop_front();
          in_ch.kind    <= op.kind;
          in_ch.pc      <= op.pc;
          in_ch.outcome <= op.outcome;
          v = 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 6);
        end
      end
      calm <= op_q.size() < CalmTail;
    end
    in_ch.valid <= v;
  end

  // result monitor
  always @(posedge clk_i) begin
    logic r;
    logic exp_taken;
    if (!rst_ni) begin
      r = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (want_taken.size() == 0) begin
          $error("taken: no prediction pending, got %0b", out_ch.taken);
          errors++;
        end else begin
          exp_taken = want_taken.pop_front();
          if (out_ch.taken !== exp_taken) begin
            $error("taken: expected %0b, got %0b", exp_taken, out_ch.taken);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        r = 1'b0;
      end else begin
        r = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 6);
      end
    end
    out_ch.ready <= r;
  end

  initial begin
    logic [tgbp_pkg::PcWidth-1:0] pc;
    int unsigned b;
    int unsigned pick;

    // corners: reset predictions, saturation both ways, all pc bits
    queue_op(tgbp_pkg::KindPredict, 32'h0000_0000, 1'b1);
    queue_op(tgbp_pkg::KindPredict, 32'hFFFF_FFFF, 1'b0);
    for (int i = 0; i < 5; i++) queue_op(tgbp_pkg::KindTrain, 32'h0000_0040, 1'b1);
    queue_op(tgbp_pkg::KindPredict, 32'h0000_0043, 1'b0);
    for (int i = 0; i < 5; i++) queue_op(tgbp_pkg::KindTrain, 32'h0000_0040, 1'b0);
    queue_op(tgbp_pkg::KindPredict, 32'h0000_0040, 1'b1);
    queue_op(tgbp_pkg::KindTrain, 32'hFFFF_FFFF, 1'b1);
    queue_op(tgbp_pkg::KindTrain, 32'hFFFF_FFFF, 1'b1);
    queue_op(tgbp_pkg::KindTrain, 32'hFFFF_FFFF, 1'b1);
    queue_op(tgbp_pkg::KindPredict, 32'hFFFF_FFFC, 1'b0);
    queue_op(tgbp_pkg::KindTrain, 32'hFFFF_FFFF, 1'b0);
    queue_op(tgbp_pkg::KindPredict, 32'hFFFF_FFFF, 1'b1);
    queue_op(tgbp_pkg::KindTrain, 32'h0000_0000, 1'b0);
    queue_op(tgbp_pkg::KindPredict, 32'h0000_0000, 1'b0);

    for (int i = 0; i < HotCount; i++) begin
      br_pc[i]     = $urandom();
      br_mode[i]   = $urandom_range(0, 4);
      br_period[i] = $urandom_range(2, 7);
      br_phase[i]  = 0;
    end

    // mostly predict-then-resolve on hot branches, some noise
    while (op_q.size() < RandItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        pc = $urandom();
        queue_op(tgbp_pkg::kind_e'(1'($urandom_range(0, 1))), pc,
                 1'($urandom_range(0, 1)));
      end else begin
        b = $urandom_range(0, HotCount - 1);
        if (pick < 17) begin
          queue_op(tgbp_pkg::KindPredict, br_pc[b], 1'($urandom_range(0, 1)));
        end
        queue_op(tgbp_pkg::KindTrain, br_pc[b], branch_dir(b));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(op_q.size() == 0 && !in_ch.valid && want_taken.size() == 0)
           && cycle_cnt < CycleLimit)
      @(posedge clk_i);

    if (cycle_cnt >= CycleLimit) begin
      $display("tournament_gshare_bimodal_predictor test failed");
    end else begin
      repeat (16) @(posedge clk_i);
      if (want_taken.size() != 0) begin
        $error("taken: %0d predictions never arrived", want_taken.size());
        errors++;
      end
      if (errors == 0) begin
        $display("tournament_gshare_bimodal_predictor test passed");
      end else begin
        $display("tournament_gshare_bimodal_predictor test failed");
      end
    end
    $finish;
  end

endmodule

// File: files.f
sv/tgbp_pkg.sv
sv/tgbp_if.sv
sv/tournament_gshare_bimodal_predictor.sv
sim/tournament_gshare_bimodal_predictor_tb.sv
